/* rtl/core/tcsm_pkg.sv */
// Shared types, field widths, command and shape codes for the tile collision
// sub-step move unit. No dependencies.
package tcsm_pkg;

	localparam int TILE_IDX_W = 12;
	localparam int CODE_W     = 4;
	localparam int COORD_W    = 14;
	localparam int DELTA_W    = 15;
	localparam int QUOT_W     = DELTA_W + 1;
	localparam int STEPS_IN_W = 7;
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 2;

	localparam int DEF_MAX_SIDE      = 64;
	localparam int DEF_FRAC_BITS     = 8;
	localparam int DEF_MAX_SUB_STEPS = 64;

	localparam logic [CFG_W-1:0] MAP_SIDE_RESET = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_MOVE = 1'b1;

	localparam logic [CODE_W-1:0] SHAPE_FULL   = 4'd1;
	localparam logic [CODE_W-1:0] SHAPE_OUT_TL = 4'd2;
	localparam logic [CODE_W-1:0] SHAPE_OUT_T  = 4'd3;
	localparam logic [CODE_W-1:0] SHAPE_OUT_TR = 4'd4;
	localparam logic [CODE_W-1:0] SHAPE_OUT_L  = 4'd5;
	localparam logic [CODE_W-1:0] SHAPE_OUT_R  = 4'd6;
	localparam logic [CODE_W-1:0] SHAPE_OUT_BL = 4'd7;
	localparam logic [CODE_W-1:0] SHAPE_OUT_B  = 4'd8;
	localparam logic [CODE_W-1:0] SHAPE_OUT_BR = 4'd9;
	localparam logic [CODE_W-1:0] SHAPE_IN_TL  = 4'd10;
	localparam logic [CODE_W-1:0] SHAPE_IN_TR  = 4'd11;
	localparam logic [CODE_W-1:0] SHAPE_IN_BL  = 4'd12;
	localparam logic [CODE_W-1:0] SHAPE_IN_BR  = 4'd13;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_MOVE  = 2'd1,
		KIND_STILL = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [TILE_IDX_W-1:0]      tile_index;
		logic [CODE_W-1:0]          tile_code;
		logic [COORD_W-1:0]         start_x;
		logic [COORD_W-1:0]         start_y;
		logic signed [DELTA_W-1:0]  delta_x;
		logic signed [DELTA_W-1:0]  delta_y;
		logic [STEPS_IN_W-1:0]      step_count;
		logic                       steps_over;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic               collided;
	} res_t;

	function automatic logic shape_hit(input logic [CODE_W-1:0] code, input logic lo_x,
		input logic hi_x, input logic lo_y, input logic hi_y);
		logic h;
		case (code)
			SHAPE_FULL:   h = 1'b1;
			SHAPE_OUT_TL: h = lo_x | lo_y;
			SHAPE_OUT_T:  h = lo_y;
			SHAPE_OUT_TR: h = hi_x | lo_y;
			SHAPE_OUT_L:  h = lo_x;
			SHAPE_OUT_R:  h = hi_x;
			SHAPE_OUT_BL: h = lo_x | hi_y;
			SHAPE_OUT_B:  h = hi_y;
			SHAPE_OUT_BR: h = hi_x | hi_y;
			SHAPE_IN_TL:  h = lo_x & lo_y;
			SHAPE_IN_TR:  h = hi_x & lo_y;
			SHAPE_IN_BL:  h = lo_x & hi_y;
			SHAPE_IN_BR:  h = hi_x & hi_y;
			default:      h = 1'b0;
		endcase
		return h;
	endfunction

endpackage

/* rtl/core/tcsm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tcsm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/tcsm_front.sv */
// Front end: takes input items, classifies them and holds them in a
// two-entry command queue for the back end. Depends on tcsm_pkg.
module tcsm_front #(
	parameter int MAX_SIDE      = tcsm_pkg::DEF_MAX_SIDE,
	parameter int MAX_SUB_STEPS = tcsm_pkg::DEF_MAX_SUB_STEPS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  command,
	input  logic [tcsm_pkg::TILE_IDX_W-1:0]       tile_index,
	input  logic [tcsm_pkg::CODE_W-1:0]           tile_code,
	input  logic [tcsm_pkg::COORD_W-1:0]          start_x,
	input  logic [tcsm_pkg::COORD_W-1:0]          start_y,
	input  logic signed [tcsm_pkg::DELTA_W-1:0]   delta_x,
	input  logic signed [tcsm_pkg::DELTA_W-1:0]   delta_y,
	input  logic [tcsm_pkg::STEPS_IN_W-1:0]       step_count,
	input  logic                                  clearing,
	output logic                                  cmd_valid,
	output tcsm_pkg::cmd_t                        cmd,
	input  logic                                  cmd_pop
);
	import tcsm_pkg::*;

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;

	cmd_t       ent;
	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       in_range;
	logic       keep;
	logic       wr;

	assign full     = clearing || (cnt_q == 2'd2);
	assign accept   = push && !full;
	assign in_range = 32'(tile_index) < 32'(DEPTH);
	assign keep     = (command == CMD_MOVE) || in_range;
	assign wr       = accept && keep;

	always_comb begin
		ent.tile_index = tile_index;
		ent.tile_code  = tile_code;
		ent.start_x    = start_x;
		ent.start_y    = start_y;
		ent.delta_x    = delta_x;
		ent.delta_y    = delta_y;
		ent.step_count = step_count;
		ent.steps_over = 32'(step_count) > 32'(MAX_SUB_STEPS);
		if (command == CMD_LOAD) begin
			ent.kind = KIND_LOAD;
		end else if (step_count == '0) begin
			ent.kind = KIND_STILL;
		end else begin
			ent.kind = KIND_MOVE;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			case ({wr, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_q];

endmodule

/* rtl/core/tcsm_div.sv */
// Two-lane restoring divider, one quotient bit per cycle, signed dividend by
// unsigned divisor, truncating toward zero. Depends on tcsm_pkg.
module tcsm_div #(
	parameter int STEPS_W = 7
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [1:0][tcsm_pkg::DELTA_W-1:0]           dividend,
	input  logic [STEPS_W-1:0]                          divisor,
	output logic                                        valid,
	output logic [1:0][tcsm_pkg::QUOT_W-1:0]            quotient
);
	import tcsm_pkg::*;

	localparam int NUM_W = DELTA_W;
	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

	logic               busy_q;
	logic               valid_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STEPS_W-1:0] div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q  <= 1'b0;
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
		end
	end

	assign valid = valid_q;

	for (genvar g = 0; g < 2; g++) begin : g_lane
		logic [NUM_W-1:0]   num_q;
		logic [STEPS_W-1:0] rem_q;
		logic               neg_q;
		logic [STEPS_W:0]   trial;
		logic [STEPS_W:0]   diff;
		logic               take;
		logic [NUM_W-1:0]   mag_in;
		logic [QUOT_W-1:0]  mag;

		assign trial  = {rem_q, num_q[NUM_W-1]};
		assign take   = trial >= {1'b0, div_q};
		assign diff   = trial - {1'b0, div_q};
		assign mag_in = dividend[g][NUM_W-1] ? (~dividend[g] + 1'b1) : dividend[g];
		assign mag    = {1'b0, num_q};

		always_ff @(posedge clk) begin
			if (start) begin
				num_q <= mag_in;
				rem_q <= '0;
				neg_q <= dividend[g][NUM_W-1];
			end else if (busy_q) begin
				num_q <= {num_q[NUM_W-2:0], take};
				rem_q <= take ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
			end
		end

		assign quotient[g] = neg_q ? (~mag + 1'b1) : mag;
	end

endmodule

/* rtl/core/tcsm_back.sv */
// Back end: clears and updates the collision map, runs the sub-step walk of
// each move and hands results out. Depends on tcsm_pkg, tcsm_div, tcsm_ram.
module tcsm_back #(
	parameter int MAX_SIDE      = tcsm_pkg::DEF_MAX_SIDE,
	parameter int FRAC_BITS     = tcsm_pkg::DEF_FRAC_BITS,
	parameter int MAX_SUB_STEPS = tcsm_pkg::DEF_MAX_SUB_STEPS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [$clog2(MAX_SIDE+1)-1:0]  w_lim,
	input  logic [$clog2(MAX_SIDE+1)-1:0]  h_lim,
	input  logic                           cmd_valid,
	input  tcsm_pkg::cmd_t                 cmd,
	output logic                           cmd_pop,
	output logic                           res_valid,
	output tcsm_pkg::res_t                 res,
	input  logic                           res_ready,
	output logic                           clearing
);
	import tcsm_pkg::*;

	localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
	localparam int SIDE_W0 = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int STEPS_W = $clog2(MAX_SUB_STEPS + 1);
	localparam int POS_W   = (COORD_W > SIDE_W0 + FRAC_BITS) ? COORD_W : SIDE_W0 + FRAC_BITS;
	localparam int NXT_W   = POS_W + 2;
	localparam int COL_W   = NXT_W - 1 - FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] QTR   = FRAC_BITS'(1 << (FRAC_BITS - 2));
	localparam logic [FRAC_BITS-1:0] THREE = FRAC_BITS'(3 << (FRAC_BITS - 2));
	localparam logic [ADDR_W-1:0]    CLR_LAST = ADDR_W'(DEPTH - 1);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_DIV   = 8'b0000_0100,
		ST_XADDR = 8'b0000_1000,
		ST_XCHK  = 8'b0001_0000,
		ST_YADDR = 8'b0010_0000,
		ST_YCHK  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} bk_state_t;

	bk_state_t                 state_q;
	logic [ADDR_W-1:0]         clr_addr_q;
	logic [POS_W-1:0]          x_q;
	logic [POS_W-1:0]          y_q;
	logic signed [QUOT_W-1:0]  dx_q;
	logic signed [QUOT_W-1:0]  dy_q;
	logic [STEPS_W-1:0]        steps_q;
	logic                      coll_q;
	logic [POS_W-1:0]          p_q;
	logic                      off_q;
	logic                      lo_x_q;
	logic                      hi_x_q;
	logic                      lo_y_q;
	logic                      hi_y_q;

	logic                      div_start;
	logic                      div_valid;
	logic [1:0][QUOT_W-1:0]    div_quot;
	logic [STEPS_W-1:0]        steps_eff;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [CODE_W-1:0]         ram_wdata;
	logic [ADDR_W-1:0]         ram_raddr;
	logic [CODE_W-1:0]         ram_rdata;

	logic                      phase_y;
	logic signed [NXT_W-1:0]   x_s;
	logic signed [NXT_W-1:0]   y_s;
	logic signed [NXT_W-1:0]   px;
	logic signed [NXT_W-1:0]   py;
	logic [COL_W-1:0]          col;
	logic [COL_W-1:0]          row;
	logic [SIDE_W0+SIDE_W-1:0] prod;
	logic                      off;
	logic                      hit;

	assign clearing  = (state_q == ST_CLEAR);
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign div_start = cmd_pop && (cmd.kind == KIND_MOVE);
	assign steps_eff = cmd.steps_over ? STEPS_W'(MAX_SUB_STEPS) : STEPS_W'(cmd.step_count);

	tcsm_div #(
		.STEPS_W (STEPS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({cmd.delta_y, cmd.delta_x}),
		.divisor  (steps_eff),
		.valid    (div_valid),
		.quotient (div_quot)
	);

	assign ram_we    = clearing || (cmd_pop && (cmd.kind == KIND_LOAD));
	assign ram_waddr = clearing ? clr_addr_q : ADDR_W'(cmd.tile_index);
	assign ram_wdata = clearing ? '0 : cmd.tile_code;

	tcsm_ram #(
		.WIDTH (CODE_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign phase_y = (state_q == ST_YADDR);
	assign x_s     = NXT_W'($signed({1'b0, x_q}));
	assign y_s     = NXT_W'($signed({1'b0, y_q}));
	assign px      = phase_y ? x_s : x_s + NXT_W'(dx_q);
	assign py      = phase_y ? y_s + NXT_W'(dy_q) : y_s;
	assign col     = px[NXT_W-2:FRAC_BITS];
	assign row     = py[NXT_W-2:FRAC_BITS];
	assign off     = px[NXT_W-1] || py[NXT_W-1] || (col >= COL_W'(w_lim))
		|| (row >= COL_W'(h_lim));
	assign prod      = row[SIDE_W0-1:0] * w_lim;
	assign ram_raddr = ADDR_W'(prod) + ADDR_W'(col[SIDE_W0-1:0]);

	assign hit = off_q || shape_hit(ram_rdata, lo_x_q, hi_x_q, lo_y_q, hi_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							KIND_MOVE:  state_q <= ST_DIV;
							KIND_STILL: state_q <= ST_DONE;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DIV: begin
					if (div_valid) begin
						state_q <= ST_XADDR;
					end
				end
				ST_XADDR: state_q <= ST_XCHK;
				ST_XCHK:  state_q <= ST_YADDR;
				ST_YADDR: state_q <= ST_YCHK;
				ST_YCHK: begin
					state_q <= (steps_q == STEPS_W'(1)) ? ST_DONE : ST_XADDR;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					x_q     <= POS_W'(cmd.start_x);
					y_q     <= POS_W'(cmd.start_y);
					steps_q <= steps_eff;
					coll_q  <= 1'b0;
				end
			end
			ST_DIV: begin
				if (div_valid) begin
					dx_q <= $signed(div_quot[0]);
					dy_q <= $signed(div_quot[1]);
				end
			end
			ST_XADDR, ST_YADDR: begin
				p_q    <= phase_y ? py[POS_W-1:0] : px[POS_W-1:0];
				off_q  <= off;
				lo_x_q <= px[FRAC_BITS-1:0] <= QTR;
				hi_x_q <= px[FRAC_BITS-1:0] > THREE;
				lo_y_q <= py[FRAC_BITS-1:0] <= QTR;
				hi_y_q <= py[FRAC_BITS-1:0] > THREE;
			end
			ST_XCHK: begin
				if (!hit) begin
					x_q <= p_q;
				end
				coll_q <= coll_q | hit;
			end
			ST_YCHK: begin
				if (!hit) begin
					y_q <= p_q;
				end
				coll_q  <= coll_q | hit;
				steps_q <= steps_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign res_valid    = (state_q == ST_DONE);
	assign res.end_x    = COORD_W'(x_q);
	assign res.end_y    = COORD_W'(y_q);
	assign res.collided = coll_q;

endmodule

/* rtl/core/tile_collision_substep_move_unit.sv */
// Top level of the tile collision sub-step move unit: configuration registers,
// result queue and the front and back ends. Depends on tcsm_pkg, tcsm_front,
// tcsm_back.
//
//   channel   signals                          transfer when
//   input     push / full + item fields        push && !full
//   result    empty / pop + end_x,end_y,coll   pop && !empty
//   config    cfg_valid / cfg_ready + idx,data cfg_valid && cfg_ready
//
// In the back end a load is written to the map when the command is taken. A
// move with N sub-steps (clamped to MAX_SUB_STEPS) runs in order: taking the
// command, the delta divider, two map reads per sub-step, each an address state
// and a check state on the map RAM's registered read port, and handing out the
// result. A move with zero sub-steps skips straight to handing out the result.
// After reset the map is cleared one tile per cycle, with full held high;
// config writes are taken meanwhile. Two commands queue between the ends and
// two results at the output.
module tile_collision_substep_move_unit #(
	parameter int MAX_SIDE      = tcsm_pkg::DEF_MAX_SIDE,
	parameter int FRAC_BITS     = tcsm_pkg::DEF_FRAC_BITS,
	parameter int MAX_SUB_STEPS = tcsm_pkg::DEF_MAX_SUB_STEPS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  command,
	input  logic [tcsm_pkg::TILE_IDX_W-1:0]       tile_index,
	input  logic [tcsm_pkg::CODE_W-1:0]           tile_code,
	input  logic [tcsm_pkg::COORD_W-1:0]          start_x,
	input  logic [tcsm_pkg::COORD_W-1:0]          start_y,
	input  logic signed [tcsm_pkg::DELTA_W-1:0]   delta_x,
	input  logic signed [tcsm_pkg::DELTA_W-1:0]   delta_y,
	input  logic [tcsm_pkg::STEPS_IN_W-1:0]       step_count,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [tcsm_pkg::COORD_W-1:0]          end_x,
	output logic [tcsm_pkg::COORD_W-1:0]          end_y,
	output logic                                  collided,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tcsm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tcsm_pkg::CFG_W-1:0]            cfg_data
);
	import tcsm_pkg::*;

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);

	logic [CFG_W-1:0]  map_width_q;
	logic [CFG_W-1:0]  map_height_q;
	logic [SIDE_W-1:0] w_lim;
	logic [SIDE_W-1:0] h_lim;

	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_pop;
	logic              bk_clearing;
	logic              bk_res_valid;
	res_t              bk_res;
	logic              bk_res_ready;

	res_t              out_q [2];
	logic              out_wr_q;
	logic              out_rd_q;
	logic [1:0]        out_cnt_q;
	logic              out_push;
	logic              out_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_SIDE_RESET;
			map_height_q <= MAP_SIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAP_WIDTH:  map_width_q  <= cfg_data;
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_lim = (32'(map_width_q) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(map_width_q);
	assign h_lim = (32'(map_height_q) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
		: SIDE_W'(map_height_q);

	tcsm_front #(
		.MAX_SIDE      (MAX_SIDE),
		.MAX_SUB_STEPS (MAX_SUB_STEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.tile_index (tile_index),
		.tile_code  (tile_code),
		.start_x    (start_x),
		.start_y    (start_y),
		.delta_x    (delta_x),
		.delta_y    (delta_y),
		.step_count (step_count),
		.clearing   (bk_clearing),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	tcsm_back #(
		.MAX_SIDE      (MAX_SIDE),
		.FRAC_BITS     (FRAC_BITS),
		.MAX_SUB_STEPS (MAX_SUB_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.w_lim     (w_lim),
		.h_lim     (h_lim),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (bk_res_valid),
		.res       (bk_res),
		.res_ready (bk_res_ready),
		.clearing  (bk_clearing)
	);

	assign bk_res_ready = (out_cnt_q != 2'd2);
	assign out_push     = bk_res_valid && bk_res_ready;
	assign out_pop      = pop && !empty;

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_q[out_wr_q] <= bk_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (out_push) begin
				out_wr_q <= ~out_wr_q;
			end
			if (out_pop) begin
				out_rd_q <= ~out_rd_q;
			end
			case ({out_push, out_pop})
				2'b10:   out_cnt_q <= out_cnt_q + 2'd1;
				2'b01:   out_cnt_q <= out_cnt_q - 2'd1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	assign empty    = (out_cnt_q == 2'd0);
	assign end_x    = out_q[out_rd_q].end_x;
	assign end_y    = out_q[out_rd_q].end_y;
	assign collided = out_q[out_rd_q].collided;

`ifndef NO_ASSERTIONS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		bk_clearing |-> full)
		else $error("input accepted during map clear");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_res_valid && !bk_res_ready) |=> (bk_res_valid && $stable(bk_res)))
		else $error("back end result changed while result queue full");

	a_no_phantom_result: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !bk_res_valid) |=> empty)
		else $error("result queue filled without a back end result");
`endif

endmodule

/* tb/tile_collision_substep_move_unit_test.sv */
// Self-checking testbench for tile_collision_substep_move_unit: tile loads and
// sub-stepped moves against a predictor of the collision map, several map sizes.
// Depends on tcsm_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tile_collision_substep_move_unit_test;
	import tcsm_pkg::*;

	localparam int FRAC          = DEF_FRAC_BITS;
	localparam int SIDE          = DEF_MAX_SIDE;
	localparam int STEP_CAP      = DEF_MAX_SUB_STEPS;
	localparam int MAP_DEPTH     = SIDE * SIDE;
	localparam int CELL          = 1 << FRAC;
	localparam int QUARTER       = 1 << (FRAC - 2);
	localparam int THREE_QUARTER = 3 * QUARTER;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 152;

	typedef struct {
		logic                      command;
		logic [TILE_IDX_W-1:0]     tile_index;
		logic [CODE_W-1:0]         tile_code;
		logic [COORD_W-1:0]        start_x;
		logic [COORD_W-1:0]        start_y;
		logic signed [DELTA_W-1:0] delta_x;
		logic signed [DELTA_W-1:0] delta_y;
		logic [STEPS_IN_W-1:0]     step_count;
	} tile_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic command = CMD_LOAD;
	logic [TILE_IDX_W-1:0] tile_index = '0;
	logic [CODE_W-1:0] tile_code = '0;
	logic [COORD_W-1:0] start_x = '0;
	logic [COORD_W-1:0] start_y = '0;
	logic signed [DELTA_W-1:0] delta_x = '0;
	logic signed [DELTA_W-1:0] delta_y = '0;
	logic [STEPS_IN_W-1:0] step_count = '0;
	logic empty;
	logic pop = 1'b0;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;
	logic collided;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MAP_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	logic [CODE_W-1:0] tile_shape [MAP_DEPTH] = '{default: '0};
	int map_w = MAP_SIDE_RESET;
	int map_h = MAP_SIDE_RESET;

	tile_cmd_t pending_cmds [$];
	res_t expected_moves [$];
	tile_cmd_t cur_cmd;
	bit taken = 1'b0;
	int push_gap = 0;
	int pop_stall = 0;
	int push_count = 0;
	int pop_count = 0;
	bit quiet_push = 1'b0;
	bit quiet_pop = 1'b0;
	int mismatches = 0;
	int phase_w [PHASES] = '{1, 0, 9, 127, 1, 64, 65, 8, 0, 100, 3, 64};
	int phase_h [PHASES] = '{1, 9, 0, 127, 64, 1, 70, 8, 0, 5, 100, 64};

	tile_collision_substep_move_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.tile_index (tile_index),
		.tile_code  (tile_code),
		.start_x    (start_x),
		.start_y    (start_y),
		.delta_x    (delta_x),
		.delta_y    (delta_y),
		.step_count (step_count),
		.empty      (empty),
		.pop        (pop),
		.end_x      (end_x),
		.end_y      (end_y),
		.collided   (collided),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int side_cap(int v);
		return (v > SIDE) ? SIDE : v;
	endfunction

	function automatic bit tile_blocked(longint px, longint py);
		longint w, h, col, row, idx, fx, fy;
		bit lx, hx, ly, hy;
		w = side_cap(map_w);
		h = side_cap(map_h);
		if (px < 0 || py < 0)
			return 1'b1;
		col = px >> FRAC;
		row = py >> FRAC;
		if (col >= w || row >= h)
			return 1'b1;
		idx = row * w + col;
		if (idx >= MAP_DEPTH)
			return 1'b1;
		fx = px & (CELL - 1);
		fy = py & (CELL - 1);
		lx = fx <= QUARTER;
		hx = fx > THREE_QUARTER;
		ly = fy <= QUARTER;
		hy = fy > THREE_QUARTER;
		case (tile_shape[idx])
			SHAPE_FULL:   return 1'b1;
			SHAPE_OUT_TL: return lx || ly;
			SHAPE_OUT_T:  return ly;
			SHAPE_OUT_TR: return hx || ly;
			SHAPE_OUT_L:  return lx;
			SHAPE_OUT_R:  return hx;
			SHAPE_OUT_BL: return lx || hy;
			SHAPE_OUT_B:  return hy;
			SHAPE_OUT_BR: return hx || hy;
			SHAPE_IN_TL:  return lx && ly;
			SHAPE_IN_TR:  return hx && ly;
			SHAPE_IN_BL:  return lx && hy;
			SHAPE_IN_BR:  return hx && hy;
			default:      return 1'b0;
		endcase
	endfunction

	function automatic res_t predict_move(tile_cmd_t c);
		longint px, py, step_x, step_y;
		int n;
		res_t r;
		px = c.start_x;
		py = c.start_y;
		n = (c.step_count > STEP_CAP) ? STEP_CAP : c.step_count;
		r.collided = 1'b0;
		if (n > 0) begin
			step_x = longint'(c.delta_x) / n;
			step_y = longint'(c.delta_y) / n;
			for (int i = 0; i < n; i++) begin
				if (tile_blocked(px + step_x, py))
					r.collided = 1'b1;
				else
					px = px + step_x;
				if (tile_blocked(px, py + step_y))
					r.collided = 1'b1;
				else
					py = py + step_y;
			end
		end
		r.end_x = px[COORD_W-1:0];
		r.end_y = py[COORD_W-1:0];
		return r;
	endfunction

	function automatic void queue_cmd(tile_cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	function automatic tile_cmd_t load_cmd(int idx, int code);
		tile_cmd_t c;
		c.command = CMD_LOAD;
		c.tile_index = TILE_IDX_W'(idx);
		c.tile_code = CODE_W'(code);
		c.start_x = COORD_W'($urandom);
		c.start_y = COORD_W'($urandom);
		c.delta_x = DELTA_W'($urandom);
		c.delta_y = DELTA_W'($urandom);
		c.step_count = STEPS_IN_W'($urandom);
		return c;
	endfunction

	function automatic tile_cmd_t move_cmd(int sx, int sy, int dx, int dy, int n);
		tile_cmd_t c;
		c.command = CMD_MOVE;
		c.tile_index = TILE_IDX_W'($urandom);
		c.tile_code = CODE_W'($urandom);
		c.start_x = COORD_W'(sx);
		c.start_y = COORD_W'(sy);
		c.delta_x = DELTA_W'(dx);
		c.delta_y = DELTA_W'(dy);
		c.step_count = STEPS_IN_W'(n);
		return c;
	endfunction

	function automatic int random_coord(int eff, bit narrow);
		int span;
		span = (narrow && eff > 12) ? 12 : eff;
		if (eff == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, (1 << COORD_W) - 1);
		return $urandom_range(0, span - 1) * CELL + $urandom_range(0, CELL - 1);
	endfunction

	function automatic int random_delta();
		int mag, d;
		case ($urandom_range(0, 4))
			0: mag = 32;
			1: mag = 256;
			2: mag = 1024;
			3: mag = 4096;
			default: mag = 16384;
		endcase
		d = $urandom_range(0, 2 * mag) - mag;
		return (d > 16383) ? 16383 : d;
	endfunction

	function automatic int random_steps();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return 0;
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 88)
			return $urandom_range(9, 32);
		if (r < 96)
			return $urandom_range(33, STEP_CAP);
		return $urandom_range(STEP_CAP + 1, (1 << STEPS_IN_W) - 1);
	endfunction

	function automatic tile_cmd_t random_cmd();
		int ew, eh, sw, sh;
		bit narrow;
		ew = side_cap(map_w);
		eh = side_cap(map_h);
		narrow = $urandom_range(0, 1);
		if ($urandom_range(0, 99) < 35) begin
			sw = (narrow && ew > 12) ? 12 : ew;
			sh = (narrow && eh > 12) ? 12 : eh;
			if (sw == 0 || sh == 0 || $urandom_range(0, 99) < 15)
				return load_cmd($urandom_range(0, MAP_DEPTH - 1), $urandom_range(0, 15));
			return load_cmd($urandom_range(0, sh - 1) * ew + $urandom_range(0, sw - 1),
				$urandom_range(0, 15));
		end
		return move_cmd(random_coord(ew, narrow), random_coord(eh, narrow), random_delta(),
			random_delta(), random_steps());
	endfunction

	function automatic int gap_len(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 150);
	endfunction

	always @(posedge clk) begin
		if (push && !full) begin
			if (cur_cmd.command == CMD_LOAD)
				tile_shape[cur_cmd.tile_index] = cur_cmd.tile_code;
			else
				expected_moves.insert(expected_moves.size(), predict_move(cur_cmd));
			void'(pending_cmds.pop_front());
			taken = 1'b1;
			push_count++;
			if (push_count % 64 == 0)
				quiet_push = ($urandom_range(0, 3) == 0);
			push_gap = gap_len(quiet_push);
		end
	end

	always @(negedge clk) begin
		if (push && !taken) begin
			// hold until transfer
		end else if (push_gap > 0) begin
			push <= 1'b0;
			push_gap--;
		end else if (pending_cmds.size() > 0) begin
			cur_cmd = pending_cmds[0];
			command <= cur_cmd.command;
			tile_index <= cur_cmd.tile_index;
			tile_code <= cur_cmd.tile_code;
			start_x <= cur_cmd.start_x;
			start_y <= cur_cmd.start_y;
			delta_x <= cur_cmd.delta_x;
			delta_y <= cur_cmd.delta_y;
			step_count <= cur_cmd.step_count;
			push <= 1'b1;
		end else begin
			push <= 1'b0;
		end
		taken = 1'b0;
	end

	always @(posedge clk) begin
		res_t want;
		if (pop && !empty) begin
			if (expected_moves.size() == 0) begin
				$display("%0t: unexpected result end_x %0d end_y %0d collided %0d",
					$time, end_x, end_y, collided);
				mismatches++;
			end else begin
				want = expected_moves.pop_front();
				if (end_x !== want.end_x) begin
					$display("%0t: end_x expected %0d got %0d", $time, want.end_x, end_x);
					mismatches++;
				end
				if (end_y !== want.end_y) begin
					$display("%0t: end_y expected %0d got %0d", $time, want.end_y, end_y);
					mismatches++;
				end
				if (collided !== want.collided) begin
					$display("%0t: collided expected %0d got %0d", $time, want.collided,
						collided);
					mismatches++;
				end
			end
			pop_count++;
			if (pop_count % 64 == 0)
				quiet_pop = ($urandom_range(0, 3) == 0);
			pop_stall = gap_len(quiet_pop);
		end
	end

	always @(negedge clk) begin
		if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall--;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_MAP_WIDTH)
			map_w = val;
		else
			map_h = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || expected_moves.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 1; k <= 13; k++)
			queue_cmd(load_cmd(k, k));
		queue_cmd(load_cmd(SIDE, 14));
		queue_cmd(load_cmd(MAP_DEPTH - 1, 15));
		queue_cmd(move_cmd(100, 200, 500, -500, 0));
		queue_cmd(move_cmd(CELL + 128, 128, 0, 0, 1));
		queue_cmd(move_cmd(CELL + 128, 128, CELL, 0, 1));
		queue_cmd(move_cmd(10, 10, -16384, -16384, 1));
		queue_cmd(move_cmd(16383, 16383, 16383, 16383, STEP_CAP));
		queue_cmd(move_cmd(3000, 9000, -16384, 16383, 127));
		queue_cmd(move_cmd(5 * CELL + 10, 300, 0, -200, 2));
		queue_cmd(move_cmd(10 * CELL + 32, 200, 0, -150, 3));
		queue_cmd(move_cmd(128, 2 * CELL + 128, -7, 7, 2));
		queue_cmd(move_cmd(128, 224, 14 * CELL, 0, STEP_CAP));

		phase_w[PHASES - 2] = $urandom_range(0, 127);
		phase_h[PHASES - 2] = $urandom_range(0, 127);
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_reg(REG_MAP_WIDTH, phase_w[p]);
			write_reg(REG_MAP_HEIGHT, phase_h[p]);
			for (int k = 0; k < PHASE_ITEMS; k++)
				queue_cmd(random_cmd());
		end

		while (pending_cmds.size() != 0 || expected_moves.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_moves.size() == 0)
			$display("tile_collision_substep_move_unit: match");
		else
			$display("tile_collision_substep_move_unit: mismatch");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("tile_collision_substep_move_unit: mismatch");
		$finish;
	end

endmodule

/* tile_collision_substep_move_unit.f */
rtl/core/tcsm_pkg.sv
rtl/core/tcsm_ram.sv
rtl/core/tcsm_front.sv
rtl/core/tcsm_div.sv
rtl/core/tcsm_back.sv
rtl/core/tile_collision_substep_move_unit.sv
tb/tile_collision_substep_move_unit_test.sv
